FILE: sv/cpd_pkg.sv
package cpd_pkg;

	localparam int MAX_ORDER     = 15;
	localparam int CORDIC_STAGES = 16;

	localparam int STAGE_RUN = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
	localparam int ORDER_LIM = (MAX_ORDER < 15) ? MAX_ORDER : 15;

	localparam logic [4:0] STAGE_LAST = 5'(STAGE_RUN - 1);
	localparam logic [3:0] ORDER_CAP  = 4'(ORDER_LIM);

	localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [2:0] REG_CENTER_X = 3'd0;
	localparam logic [2:0] REG_CENTER_Y = 3'd1;
	localparam logic [2:0] REG_AXIS_A_X = 3'd2;
	localparam logic [2:0] REG_AXIS_A_Y = 3'd3;
	localparam logic [2:0] REG_AXIS_B_X = 3'd4;
	localparam logic [2:0] REG_AXIS_B_Y = 3'd5;

	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] axis_a_x;
		logic signed [31:0] axis_a_y;
		logic signed [31:0] axis_b_x;
		logic signed [31:0] axis_b_y;
	} cfg_regs_t;

	// cos/sin pair in Q2.30 plus run info
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [1:0]         quad;
		logic [3:0]         order;
	} work_t;

	// arctangent of 2^-i, 2^32 per turn
	function automatic logic signed [31:0] atan_at(input logic [4:0] idx);
		logic signed [31:0] v;
		case (idx)
			5'd0:  v = 32'sd536870912;
			5'd1:  v = 32'sd316933406;
			5'd2:  v = 32'sd167458907;
			5'd3:  v = 32'sd85004756;
			5'd4:  v = 32'sd42667331;
			5'd5:  v = 32'sd21354465;
			5'd6:  v = 32'sd10679838;
			5'd7:  v = 32'sd5340245;
			5'd8:  v = 32'sd2670163;
			5'd9:  v = 32'sd1335087;
			5'd10: v = 32'sd667544;
			5'd11: v = 32'sd333772;
			5'd12: v = 32'sd166886;
			5'd13: v = 32'sd83443;
			5'd14: v = 32'sd41722;
			5'd15: v = 32'sd20861;
			5'd16: v = 32'sd10430;
			5'd17: v = 32'sd5215;
			5'd18: v = 32'sd2608;
			5'd19: v = 32'sd1304;
			5'd20: v = 32'sd652;
			5'd21: v = 32'sd326;
			5'd22: v = 32'sd163;
			5'd23: v = 32'sd81;
			5'd24: v = 32'sd41;
			5'd25: v = 32'sd20;
			5'd26: v = 32'sd10;
			5'd27: v = 32'sd5;
			5'd28: v = 32'sd3;
			5'd29: v = 32'sd1;
			5'd30: v = 32'sd1;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

endpackage

FILE: sv/cpd_front.sv
module cpd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [15:0]    angle,
	input  logic [3:0]     max_order,
	output logic           push_valid,
	input  logic           push_ready,
	output cpd_pkg::work_t push_data
);
	import cpd_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ROT  = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	logic [1:0]         state_q;
	logic [4:0]         iter_q;
	logic signed [31:0] x_q;
	logic signed [31:0] y_q;
	logic signed [31:0] z_q;
	logic [1:0]         quad_q;
	logic [3:0]         order_q;

	logic signed [31:0] dx;
	logic signed [31:0] dy;
	logic signed [31:0] at;
	logic               accept;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign push_valid = (state_q == ST_PUSH);

	assign dx = y_q >>> iter_q;
	assign dy = x_q >>> iter_q;
	assign at = atan_at(iter_q);

	assign push_data.x     = x_q;
	assign push_data.y     = y_q;
	assign push_data.quad  = quad_q;
	assign push_data.order = order_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_ROT;
						iter_q  <= '0;
					end
				end
				ST_ROT: begin
					if (iter_q == STAGE_LAST) begin
						state_q <= ST_PUSH;
					end else begin
						iter_q <= iter_q + 5'd1;
					end
				end
				ST_PUSH: begin
					if (push_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= CORDIC_X0;
			y_q     <= '0;
			z_q     <= {2'b00, angle[13:0], 16'h0000};
			quad_q  <= angle[15:14];
			order_q <= (max_order < ORDER_CAP) ? max_order : ORDER_CAP;
		end else if (state_q == ST_ROT) begin
			if (!z_q[31]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

endmodule

FILE: sv/cpd_queue.sv
module cpd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  cpd_pkg::work_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output cpd_pkg::work_t pop_data
);
	import cpd_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	work_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != FULL_CNT);
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

FILE: sv/cpd_back.sv
module cpd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  cpd_pkg::cfg_regs_t cfg,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  cpd_pkg::work_t     pop_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         deriv_index,
	output logic signed [31:0] value_x,
	output logic signed [31:0] value_y,
	output logic               saturated,
	output logic               last
);
	import cpd_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]         state_q;
	logic [2:0]         mcnt_q;
	logic [3:0]         k_q;
	logic signed [31:0] x_q;
	logic signed [31:0] y_q;
	logic [1:0]         quad_q;
	logic [3:0]         order_q;
	logic signed [63:0] p_q [8];
	logic               out_valid_q;

	logic signed [31:0] op_a;
	logic signed [31:0] op_b;
	logic signed [63:0] prod;
	logic [1:0]         rot;
	logic               neg1;
	logic               neg2;
	logic signed [65:0] ctr_x;
	logic signed [65:0] ctr_y;
	logic signed [65:0] sum_x;
	logic signed [65:0] sum_y;
	logic signed [35:0] rnd_x;
	logic signed [35:0] rnd_y;
	logic               sat_x;
	logic               sat_y;
	logic               out_free;
	logic               is_last;
	logic               emit;

	// product slot {axis, use_y}: ax*x, ax*y, bx*x, bx*y, ay*x, ay*y, by*x, by*y
	always_comb begin
		case (mcnt_q[2:1])
			2'd0:    op_a = cfg.axis_a_x;
			2'd1:    op_a = cfg.axis_b_x;
			2'd2:    op_a = cfg.axis_a_y;
			default: op_a = cfg.axis_b_y;
		endcase
		op_b = mcnt_q[0] ? y_q : x_q;
	end
	assign prod = 64'(op_a) * 64'(op_b);

	// quarter turn k: (c,s) (-s,c) (-c,-s) (s,-c)
	assign rot  = quad_q + k_q[1:0];
	assign neg1 = rot[0] ^ rot[1];
	assign neg2 = rot[1];

	function automatic logic signed [65:0] term(input logic signed [63:0] p, input logic neg);
		logic signed [65:0] e;
		e = 66'(p);
		return neg ? -e : e;
	endfunction

	assign ctr_x = (k_q == 4'd0) ? {{4{cfg.center_x[31]}}, cfg.center_x, 30'd0} : '0;
	assign ctr_y = (k_q == 4'd0) ? {{4{cfg.center_y[31]}}, cfg.center_y, 30'd0} : '0;

	assign sum_x = term(rot[0] ? p_q[1] : p_q[0], neg1)
		+ term(rot[0] ? p_q[2] : p_q[3], neg2) + ctr_x + 66'sd536870912;
	assign sum_y = term(rot[0] ? p_q[5] : p_q[4], neg1)
		+ term(rot[0] ? p_q[6] : p_q[7], neg2) + ctr_y + 66'sd536870912;

	assign rnd_x = sum_x[65:30];
	assign rnd_y = sum_y[65:30];
	assign sat_x = (rnd_x[35:31] != {5{rnd_x[31]}});
	assign sat_y = (rnd_y[35:31] != {5{rnd_y[31]}});

	assign out_free  = !out_valid_q || out_ready;
	assign is_last   = (k_q == order_q);
	assign emit      = (state_q == ST_EMIT) && out_free;
	assign pop_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mcnt_q      <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready && !emit) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= ST_MUL;
						mcnt_q  <= '0;
						k_q     <= '0;
					end
				end
				ST_MUL: begin
					mcnt_q <= mcnt_q + 3'd1;
					if (mcnt_q == 3'd7) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							k_q <= k_q + 4'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop_valid) begin
			x_q     <= pop_data.x;
			y_q     <= pop_data.y;
			quad_q  <= pop_data.quad;
			order_q <= pop_data.order;
		end
		if (state_q == ST_MUL) begin
			p_q[mcnt_q] <= prod;
		end
		if (state_q == ST_EMIT && out_free) begin
			deriv_index <= k_q;
			value_x     <= sat_x ? (rnd_x[35] ? 32'sh80000000 : 32'sh7fffffff) : rnd_x[31:0];
			value_y     <= sat_y ? (rnd_y[35] ? 32'sh80000000 : 32'sh7fffffff) : rnd_y[31:0];
			saturated   <= sat_x || sat_y;
			last        <= is_last;
		end
	end

endmodule

FILE: sv/conic_point_and_derivatives.sv
// Evaluates P(t) = center + cos t * A + sin t * B and its derivatives, Q16.16 with a
// 16-bit binary angle. Each input word yields min(max_order, 15) + 1 result words,
// deriv_index 0 first, last set on the final one; only deriv_index 0 includes the
// center, and each value is rounded and saturated (saturated flags clipping). The
// front end runs an iterative CORDIC, one stage per cycle, and accepts a new angle
// only once it has pushed the previous one into the queue. The back end forms eight
// axis products on one shared 32x32 multiplier, then emits one result per cycle
// while out_ready does not hold the output off. A two-word queue between them lets
// the two overlap. Registers are to be written through the cfg port only while the
// block is idle; the block itself does not enforce this. cfg_ready is always high
// and indexes past axis_b_y are ignored.
module conic_point_and_derivatives (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        angle,
	input  logic [3:0]         max_order,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         deriv_index,
	output logic signed [31:0] value_x,
	output logic signed [31:0] value_y,
	output logic               saturated,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import cpd_pkg::*;

	cfg_regs_t cfg_q;
	work_t     push_data;
	work_t     pop_data;
	logic      push_valid;
	logic      push_ready;
	logic      pop_valid;
	logic      pop_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x <= 32'sd0;
			cfg_q.center_y <= 32'sd0;
			cfg_q.axis_a_x <= 32'sd65536;
			cfg_q.axis_a_y <= 32'sd0;
			cfg_q.axis_b_x <= 32'sd0;
			cfg_q.axis_b_y <= 32'sd65536;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CENTER_X: cfg_q.center_x <= cfg_data;
				REG_CENTER_Y: cfg_q.center_y <= cfg_data;
				REG_AXIS_A_X: cfg_q.axis_a_x <= cfg_data;
				REG_AXIS_A_Y: cfg_q.axis_a_y <= cfg_data;
				REG_AXIS_B_X: cfg_q.axis_b_x <= cfg_data;
				REG_AXIS_B_Y: cfg_q.axis_b_y <= cfg_data;
				default: ;
			endcase
		end
	end

	cpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.angle      (angle),
		.max_order  (max_order),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	cpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	cpd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_data    (pop_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.deriv_index (deriv_index),
		.value_x     (value_x),
		.value_y     (value_y),
		.saturated   (saturated),
		.last        (last)
	);

endmodule

FILE: bench/conic_point_and_derivatives_tb.sv
`timescale 1ns / 100ps

module conic_point_and_derivatives_tb;
	import cpd_pkg::*;

	localparam int STAGES_RUN = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
	localparam int ORDER_TOP = (MAX_ORDER < 15) ? MAX_ORDER : 15;
	localparam longint GAIN_Q30 = 64'sd652032874;
	localparam logic [2:0] REG_UNMAPPED_A = 3'd6;
	localparam logic [2:0] REG_UNMAPPED_B = 3'd7;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 3000;

	typedef struct {
		logic [15:0] ang;
		logic [3:0] ord;
	} angle_req_t;

	typedef struct {
		logic [3:0] deriv_index;
		logic signed [31:0] value_x;
		logic signed [31:0] value_y;
		logic saturated;
		logic last;
	} conic_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] angle = '0;
	logic [3:0] max_order = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [3:0] deriv_index;
	logic signed [31:0] value_x;
	logic signed [31:0] value_y;
	logic saturated;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// arctangent of 2^-i, 2^32 per turn
	longint atan_turn [32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1, 1, 0
	};

	logic signed [31:0] conic_reg [0:5] = '{32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0, 32'sd65536};

	angle_req_t angle_reqs [$];
	conic_result_t conic_results_due [$];
	angle_req_t next_req;
	conic_result_t due;

	int in_idle_pct = 0;
	int out_idle_pct = 0;
	int in_gap = 0;
	int out_wait = 0;
	int out_draw;
	int hold_left = 0;
	logic hold_request = 1'b0;
	logic hold_taken = 1'b0;
	int fail_count = 0;
	int quiet_cycles = 0;

	conic_point_and_derivatives dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.angle(angle),
		.max_order(max_order),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.deriv_index(deriv_index),
		.value_x(value_x),
		.value_y(value_y),
		.saturated(saturated),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int idle_draw(input int pct);
		return ($urandom_range(0, 99) < pct) ? int'($urandom_range(0, 16)) : 0;
	endfunction

	// Q46 -> Q16.16 round half up, clip; bit 32 flags clipping
	function automatic logic [32:0] round_q16(input longint acc);
		longint r;
		r = (acc + (64'sd1 <<< 29)) >>> 30;
		if (r > 64'sd2147483647)
			return {1'b1, 32'h7FFF_FFFF};
		if (r < -64'sd2147483648)
			return {1'b1, 32'h8000_0000};
		return {1'b0, r[31:0]};
	endfunction

	function automatic void predict_conic(input logic [15:0] ang, input logic [3:0] ord);
		longint cx, cy, z, dx, dy, ck, sk, vx, vy;
		int unsigned n, k, i;
		logic [1:0] turn;
		logic sx, sy;
		conic_result_t res;
		n = (ord < ORDER_TOP) ? ord : ORDER_TOP;
		cx = GAIN_Q30;
		cy = 0;
		z = longint'(ang[13:0]) * 65536;
		for (i = 0; i < STAGES_RUN; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (z >= 0) begin
				cx -= dx;
				cy += dy;
				z -= atan_turn[i];
			end else begin
				cx += dx;
				cy -= dy;
				z += atan_turn[i];
			end
		end
		for (k = 0; k <= n; k++) begin
			turn = ang[15:14] + 2'(k);
			case (turn)
				2'd0: begin
					ck = cx;
					sk = cy;
				end
				2'd1: begin
					ck = -cy;
					sk = cx;
				end
				2'd2: begin
					ck = -cx;
					sk = -cy;
				end
				default: begin
					ck = cy;
					sk = -cx;
				end
			endcase
			vx = longint'(conic_reg[REG_AXIS_A_X]) * ck + longint'(conic_reg[REG_AXIS_B_X]) * sk;
			vy = longint'(conic_reg[REG_AXIS_A_Y]) * ck + longint'(conic_reg[REG_AXIS_B_Y]) * sk;
			if (k == 0) begin
				vx += longint'(conic_reg[REG_CENTER_X]) <<< 30;
				vy += longint'(conic_reg[REG_CENTER_Y]) <<< 30;
			end
			{sx, res.value_x} = round_q16(vx);
			{sy, res.value_y} = round_q16(vy);
			res.saturated = sx | sy;
			res.deriv_index = 4'(k);
			res.last = (k == n);
			conic_results_due = {conic_results_due, res};
		end
	endfunction

	// input side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				predict_conic(angle, max_order);
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_valid <= 1'b0;
					in_gap <= in_gap - 1;
				end else if (angle_reqs.size() != 0) begin
					next_req = angle_reqs.pop_front();
					angle <= next_req.ang;
					max_order <= next_req.ord;
					in_valid <= 1'b1;
					in_gap <= idle_draw(in_idle_pct);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_wait <= 0;
			hold_left <= 0;
			hold_taken <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (conic_results_due.size() == 0) begin
					$error("unexpected result word: deriv_index %0d", deriv_index);
					fail_count++;
				end else begin
					due = conic_results_due.pop_front();
					if (deriv_index !== due.deriv_index) begin
						$error("deriv_index expected %0d got %0d", due.deriv_index, deriv_index);
						fail_count++;
					end
					if (value_x !== due.value_x) begin
						$error("value_x expected %0d got %0d", due.value_x, value_x);
						fail_count++;
					end
					if (value_y !== due.value_y) begin
						$error("value_y expected %0d got %0d", due.value_y, value_y);
						fail_count++;
					end
					if (saturated !== due.saturated) begin
						$error("saturated expected %0b got %0b", due.saturated, saturated);
						fail_count++;
					end
					if (last !== due.last) begin
						$error("last expected %0b got %0b", due.last, last);
						fail_count++;
					end
				end
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (hold_request && !hold_taken) begin
				out_ready <= 1'b0;
				hold_left <= HOLD_CYCLES;
				hold_taken <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_draw = idle_draw(out_idle_pct);
				out_ready <= (out_draw == 0);
				out_wait <= (out_draw > 0) ? out_draw - 1 : 0;
			end else if (out_wait > 0) begin
				out_ready <= 1'b0;
				out_wait <= out_wait - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("conic_point_and_derivatives verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx <= REG_AXIS_B_Y)
			conic_reg[idx] = val;
	endtask

	task automatic load_conic(input logic [31:0] cx, input logic [31:0] cy,
			input logic [31:0] ax, input logic [31:0] ay,
			input logic [31:0] bx, input logic [31:0] by);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_AXIS_A_X, ax);
		write_reg(REG_AXIS_A_Y, ay);
		write_reg(REG_AXIS_B_X, bx);
		write_reg(REG_AXIS_B_Y, by);
		// unmapped indexes must not disturb the geometry
		write_reg(REG_UNMAPPED_A, $urandom());
		write_reg(REG_UNMAPPED_B, $urandom());
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_angle(input logic [15:0] a, input logic [3:0] o);
		angle_req_t r;
		r.ang = a;
		r.ord = o;
		angle_reqs = {angle_reqs, r};
	endtask

	task automatic drain();
		while (angle_reqs.size() != 0 || in_valid || conic_results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int count, input int in_pct, input int out_pct);
		logic [15:0] a;
		in_idle_pct = in_pct;
		out_idle_pct = out_pct;
		repeat (count) begin
			case ($urandom_range(0, 3))
				0: a = {2'($urandom_range(0, 3)), 14'($urandom_range(0, 3))};
				1: a = {2'($urandom_range(0, 3)), 14'h3FFF - 14'($urandom_range(0, 3))};
				default: a = 16'($urandom());
			endcase
			queue_angle(a, 4'($urandom_range(0, 15)));
		end
		drain();
	endtask

	function automatic logic [31:0] moderate();
		return 32'($urandom_range(0, 26214400)) - 32'd13107200;
	endfunction

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unit circle from reset
		queue_angle(16'h0000, 4'd0);
		queue_angle(16'h0000, 4'd15);
		queue_angle(16'h4000, 4'd3);
		queue_angle(16'h8000, 4'd4);
		queue_angle(16'hC000, 4'd5);
		queue_angle(16'hFFFF, 4'd15);
		queue_angle(16'h3FFF, 4'd2);
		queue_angle(16'h0001, 4'd1);
		queue_angle(16'h2000, 4'd7);
		queue_angle(16'hFFFF, 4'd0);
		queue_angle(16'h7FFF, 4'd8);
		queue_angle(16'h4001, 4'd6);
		queue_angle(16'hA5A5, 4'd10);
		queue_angle(16'h5A5A, 4'd11);
		queue_angle(16'hBFFF, 4'd12);
		queue_angle(16'h8001, 4'd13);
		queue_angle(16'h1234, 4'd14);
		queue_angle(16'hEDCB, 4'd9);
		drain();

		// moderate ellipse, receiver held off while sender streams
		load_conic(moderate(), moderate(), moderate(), moderate(), moderate(), moderate());
		hold_request = 1'b1;
		run_phase(80, 0, 30);

		// extreme registers, forces clipping
		load_conic(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
				32'h8000_0000, 32'h7FFF_FFFF);
		queue_angle(16'h0000, 4'd15);
		queue_angle(16'h2000, 4'd15);
		queue_angle(16'hE000, 4'd3);
		run_phase(80, 40, 40);

		// degenerate axes: point is the center, derivatives vanish
		load_conic(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0);
		run_phase(80, 80, 80);

		load_conic($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
		run_phase(80, 0, 0);

		load_conic(moderate(), moderate(), moderate(), moderate(), moderate(), moderate());
		run_phase(80, 15, 70);

		repeat (40) @(posedge clk);
		if (fail_count == 0 && conic_results_due.size() == 0)
			$display("conic_point_and_derivatives verification clean");
		else
			$display("conic_point_and_derivatives verification failed");
		$finish;
	end

endmodule
